### hdl/lca_pkg.sv
package lca_pkg;

   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 11;
   localparam int ID_W      = $clog2(MAX_NODES);
   localparam int LVL_W     = $clog2(LEVELS);
   localparam int CNT_W     = ID_W + 1;
   localparam int JT_DEPTH  = MAX_NODES * (2 ** LVL_W);

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_DEL = 2'd1;
   localparam logic [1:0] MODE_QRY = 2'd2;
   localparam logic [1:0] MODE_NOP = 2'd3;

   typedef struct packed {
      logic            flag;
      logic [ID_W-1:0] depth;
      logic [ID_W-1:0] link;
   } node_entry_type;

   typedef struct packed {
      logic            we;
      logic [ID_W-1:0] addr;
      node_entry_type  wdata;
   } node_req_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_P,
      ST_ADD_V,
      ST_ADD_W,
      ST_ADD_JR,
      ST_ADD_JW,
      ST_DEL_R,
      ST_DEL_W,
      ST_Q_A,
      ST_Q_B,
      ST_Q_S,
      ST_LIFT,
      ST_LIFT_W,
      ST_CMP,
      ST_UP_A,
      ST_UP_B,
      ST_UP_C,
      ST_TOP,
      ST_TOP_W,
      ST_CH_R,
      ST_CH_W,
      ST_CP_R,
      ST_CP_W,
      ST_RESP
   } state_type;

endpackage

### hdl/lca_node_store.sv
module lca_node_store import lca_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  node_req_type   req,
   output node_entry_type rdata,
   output logic           busy
);

   node_entry_type       mem [MAX_NODES];
   node_entry_type       rdata_ff;
   logic [CNT_W-1:0]     clr_cnt_ff;
   logic [CNT_W-1:0]     clr_cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 we;
   logic [ID_W-1:0]      waddr;
   node_entry_type       wdata;

   // sweep every entry after reset: flags clear, root links to itself
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         clr_cnt_in = clr_cnt_ff + CNT_W'(1);
         if (clr_cnt_ff == CNT_W'(MAX_NODES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (busy_ff) begin
         we          = 1'b1;
         waddr       = clr_cnt_ff[ID_W-1:0];
         wdata.flag  = 1'b0;
         wdata.depth = '0;
         wdata.link  = (clr_cnt_ff == CNT_W'(1)) ? ID_W'(1) : '0;
      end else begin
         we    = req.we;
         waddr = req.addr;
         wdata = req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

### hdl/lca_alive_ancestor_engine_unit.sv
// Channel   Ports                                  Direction
// request   req_valid req_ready req_mode/node_a/b  in
// response  rsp_valid rsp_ready rsp_ancestor       out
//
// One item at a time. Add writes the new node and builds its jump rows; Delete sets the node's flag.
// Query lifts the deeper node by the depth difference, lifts both while their ancestors differ,
// then follows alive links and points each deleted node on the path at the survivor.
// After reset the node memory is swept; req_ready rises once the sweep is done.
// A waiting result holds the block in its response state until rsp_ready.
module lca_alive_ancestor_engine_unit import lca_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_mode,
   input  logic [ID_W-1:0] req_node_a,
   input  logic [ID_W-1:0] req_node_b,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [ID_W-1:0] rsp_ancestor
);

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  a_ff, a_in, b_ff, b_in, da_ff, da_in;
   logic [LEVELS-1:0] h_ff, h_in;
   logic [ID_W-1:0]  pa_ff, pa_in, cur_ff, cur_in, start_ff, start_in;
   logic [ID_W-1:0]  walk_ff, walk_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [CNT_W-1:0] steps_ff, steps_in, next_id_ff, next_id_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  rsp_ancestor_ff, rsp_ancestor_in;

   logic [ID_W-1:0]  jump_mem [JT_DEPTH];
   logic [ID_W-1:0]  jrd_ff;
   logic             jmask_ff;
   logic [ID_W-1:0]  jdata;
   logic [ID_W-1:0]  j_node;
   logic [LVL_W-1:0] j_lvl;
   logic             j_we;
   logic [ID_W-1:0]  j_wnode;
   logic [LVL_W-1:0] j_wlvl;
   logic [ID_W-1:0]  j_wdata;

   node_req_type     nreq;
   node_entry_type   nrd;
   logic             clr_busy;
   logic             resp_load;
   logic [ID_W-1:0]  v_id;

   lca_node_store u_node_store (
      .clock (clock),
      .reset (reset),
      .req   (nreq),
      .rdata (nrd),
      .busy  (clr_busy)
   );

   // rows of the null node and the root read as zero
   assign jdata     = jmask_ff ? '0 : jrd_ff;
   assign v_id      = next_id_ff[ID_W-1:0];
   assign resp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (j_we) begin
         jump_mem[{j_wnode, j_wlvl}] <= j_wdata;
      end
      jrd_ff   <= jump_mem[{j_node, j_lvl}];
      jmask_ff <= (j_node[ID_W-1:1] == '0);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (!clr_busy) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               priority if (req_mode == MODE_ADD) begin
                  if (next_id_ff != CNT_W'(MAX_NODES)) state_in = ST_ADD_P;
               end else if (req_mode == MODE_DEL) begin
                  state_in = ST_DEL_R;
               end else if (req_mode == MODE_QRY) begin
                  state_in = ST_Q_A;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ADD_P:  state_in = ST_ADD_V;
         ST_ADD_V:  state_in = ST_ADD_W;
         ST_ADD_W:  state_in = ST_ADD_JR;
         ST_ADD_JR: state_in = ST_ADD_JW;
         ST_ADD_JW: state_in = (lvl_ff == LVL_W'(LEVELS - 1)) ? ST_IDLE : ST_ADD_JR;
         ST_DEL_R:  state_in = ST_DEL_W;
         ST_DEL_W:  state_in = ST_IDLE;
         ST_Q_A:    state_in = ST_Q_B;
         ST_Q_B:    state_in = ST_Q_S;
         ST_Q_S:    state_in = ST_LIFT;
         ST_LIFT: begin
            if (h_ff[lvl_ff]) state_in = ST_LIFT_W;
            else if (lvl_ff == '0) state_in = ST_CMP;
         end
         ST_LIFT_W: state_in = (lvl_ff == '0) ? ST_CMP : ST_LIFT;
         ST_CMP:    state_in = (a_ff == b_ff) ? ST_CH_R : ST_UP_A;
         ST_UP_A:   state_in = ST_UP_B;
         ST_UP_B:   state_in = ST_UP_C;
         ST_UP_C:   state_in = (lvl_ff == '0) ? ST_TOP : ST_UP_A;
         ST_TOP:    state_in = ST_TOP_W;
         ST_TOP_W:  state_in = ST_CH_R;
         ST_CH_R:   state_in = ST_CH_W;
         ST_CH_W: begin
            if (nrd.flag && steps_ff < CNT_W'(MAX_NODES)) state_in = ST_CH_R;
            else if (nrd.flag) state_in = ST_RESP;
            else state_in = ST_CP_R;
         end
         ST_CP_R:   state_in = ST_CP_W;
         ST_CP_W:   state_in = nrd.flag ? ST_CP_R : ST_RESP;
         ST_RESP:   if (resp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      a_in            = a_ff;
      b_in            = b_ff;
      h_in            = h_ff;
      da_in           = da_ff;
      pa_in           = pa_ff;
      cur_in          = cur_ff;
      start_in        = start_ff;
      walk_in         = walk_ff;
      lvl_in          = lvl_ff;
      steps_in        = steps_ff;
      next_id_in      = next_id_ff;
      rsp_ancestor_in = rsp_ancestor_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      req_ready       = (state_ff == ST_IDLE);
      j_node          = b_ff;
      j_lvl           = lvl_ff;
      j_we            = 1'b0;
      j_wnode         = v_id;
      j_wlvl          = lvl_ff;
      j_wdata         = jdata;
      nreq.we         = 1'b0;
      nreq.addr       = a_ff;
      nreq.wdata      = nrd;
      unique case (state_ff)
         ST_IDLE: begin
            a_in = req_node_a;
            b_in = req_node_b;
         end
         ST_ADD_V: begin
            da_in     = nrd.depth;
            nreq.addr = v_id;
         end
         ST_ADD_W: begin
            // keep a flag set by an earlier delete of this id
            nreq.we          = 1'b1;
            nreq.addr        = v_id;
            nreq.wdata.flag  = nrd.flag;
            nreq.wdata.depth = da_ff + ID_W'(1);
            nreq.wdata.link  = a_ff;
            j_we             = 1'b1;
            j_wlvl           = '0;
            j_wdata          = a_ff;
            b_in             = a_ff;
            lvl_in           = LVL_W'(1);
            next_id_in       = next_id_ff + CNT_W'(1);
         end
         ST_ADD_JR: begin
            j_lvl = lvl_ff - LVL_W'(1);
         end
         ST_ADD_JW: begin
            j_we    = 1'b1;
            j_wnode = next_id_ff[ID_W-1:0] - ID_W'(1);
            b_in    = jdata;
            lvl_in  = lvl_ff + LVL_W'(1);
         end
         ST_DEL_W: begin
            nreq.we         = 1'b1;
            nreq.wdata.flag = 1'b1;
         end
         ST_Q_B: begin
            da_in     = nrd.depth;
            nreq.addr = b_ff;
         end
         ST_Q_S: begin
            lvl_in = LVL_W'(LEVELS - 1);
            if (da_ff > nrd.depth) begin
               a_in = b_ff;
               b_in = a_ff;
               h_in = LEVELS'(da_ff - nrd.depth);
            end else begin
               h_in = LEVELS'(nrd.depth - da_ff);
            end
         end
         ST_LIFT: begin
            if (!h_ff[lvl_ff] && lvl_ff != '0) lvl_in = lvl_ff - LVL_W'(1);
         end
         ST_LIFT_W: begin
            b_in = jdata;
            if (lvl_ff != '0) lvl_in = lvl_ff - LVL_W'(1);
         end
         ST_CMP: begin
            cur_in   = a_ff;
            start_in = a_ff;
            steps_in = '0;
            lvl_in   = LVL_W'(LEVELS - 1);
         end
         ST_UP_A: begin
            j_node = a_ff;
         end
         ST_UP_B: begin
            pa_in = jdata;
         end
         ST_UP_C: begin
            if (pa_ff != jdata) begin
               a_in = pa_ff;
               b_in = jdata;
            end
            if (lvl_ff != '0) lvl_in = lvl_ff - LVL_W'(1);
         end
         ST_TOP: begin
            j_node = a_ff;
            j_lvl  = '0;
         end
         ST_TOP_W: begin
            cur_in   = jdata;
            start_in = jdata;
            steps_in = '0;
         end
         ST_CH_R: begin
            nreq.addr = cur_ff;
         end
         ST_CH_W: begin
            walk_in = start_ff;
            if (nrd.flag && steps_ff < CNT_W'(MAX_NODES)) begin
               cur_in   = nrd.link;
               steps_in = steps_ff + CNT_W'(1);
            end
         end
         ST_CP_R: begin
            nreq.addr = walk_ff;
         end
         ST_CP_W: begin
            // point each deleted node on the path straight at the survivor
            nreq.addr = walk_ff;
            if (nrd.flag) begin
               nreq.we         = 1'b1;
               nreq.wdata.link = cur_ff;
               walk_in         = nrd.link;
            end
         end
         ST_RESP: begin
            if (resp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_ancestor_in = cur_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         next_id_ff   <= CNT_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff            <= a_in;
      b_ff            <= b_in;
      h_ff            <= h_in;
      da_ff           <= da_in;
      pa_ff           <= pa_in;
      cur_ff          <= cur_in;
      start_ff        <= start_in;
      walk_ff         <= walk_in;
      lvl_ff          <= lvl_in;
      steps_ff        <= steps_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;

   a_ready_after_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !clr_busy)
      else $error("request taken during clearing sweep");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!j_we && !nreq.we))
      else $error("memory write while idle");

   a_next_id_range: assert property (@(posedge clock) disable iff (reset)
      (next_id_ff >= CNT_W'(2)) && (next_id_ff <= CNT_W'(MAX_NODES)))
      else $error("next id out of range");

endmodule

### sim/lca_checker.sv
module lca_checker import lca_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  logic [1:0]      req_mode,
   input  logic [ID_W-1:0] req_node_a,
   input  logic [ID_W-1:0] req_node_b,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic [ID_W-1:0] rsp_ancestor,
   output int              pending_answers,
   output int              error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ID_W-1:0] lift_row [MAX_NODES][LEVELS];
   logic [ID_W-1:0] node_depth [MAX_NODES];
   logic [ID_W-1:0] alive_up [MAX_NODES];
   logic            gone [MAX_NODES];
   logic [CNT_W-1:0] free_id;
   logic [ID_W-1:0] answer_q [$];

   assign pending_answers = answer_q.size();

   function automatic logic [ID_W-1:0] nearest_alive(logic [ID_W-1:0] start);
      logic [ID_W-1:0] cur, walk, nxt;
      int steps;
      cur = start;
      steps = 0;
      while (gone[cur] && steps < MAX_NODES) begin
         cur = alive_up[cur];
         steps++;
      end
      if (!gone[cur]) begin
         walk = start;
         steps = 0;
         // compress every hop of the walked path onto the survivor
         while (gone[walk] && steps < MAX_NODES) begin
            nxt = alive_up[walk];
            alive_up[walk] = cur;
            walk = nxt;
            steps++;
         end
      end
      return cur;
   endfunction

   function automatic logic [ID_W-1:0] common_alive(logic [ID_W-1:0] a,
                                                    logic [ID_W-1:0] b);
      logic [ID_W-1:0] t, pa, pb;
      int h;
      if (node_depth[a] > node_depth[b]) begin
         t = a; a = b; b = t;
      end
      h = node_depth[b] - node_depth[a];
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if ((1 << i) <= h) begin
            h -= (1 << i);
            b = lift_row[b][i];
         end
      end
      if (a == b) return nearest_alive(a);
      for (int i = LEVELS - 1; i >= 0; i--) begin
         pa = lift_row[a][i];
         pb = lift_row[b][i];
         if (pa != pb) begin
            a = pa;
            b = pb;
         end
      end
      return nearest_alive(lift_row[a][0]);
   endfunction

   function automatic void attach_child(logic [ID_W-1:0] parent);
      logic [ID_W-1:0] v;
      if (free_id >= MAX_NODES) return;
      v = free_id[ID_W-1:0];
      alive_up[v] = parent;
      node_depth[v] = node_depth[parent] + 1'b1;
      lift_row[v][0] = parent;
      for (int i = 1; i < LEVELS; i++)
         lift_row[v][i] = lift_row[lift_row[v][i-1]][i-1];
      free_id = free_id + 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_NODES; n++) begin
            for (int l = 0; l < LEVELS; l++) lift_row[n][l] = '0;
            node_depth[n] = '0;
            alive_up[n] = '0;
            gone[n] = 1'b0;
         end
         alive_up[1] = ID_W'(1);
         free_id = CNT_W'(2);
         answer_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response beat: ancestor=%0d", rsp_ancestor);
            end else begin
               if (rsp_ancestor !== answer_q[0]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("ancestor mismatch: expected %0d, got %0d",
                              answer_q[0], rsp_ancestor);
               end
               void'(answer_q.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            case (req_mode)
               MODE_ADD: attach_child(req_node_a);
               MODE_DEL: gone[req_node_a] = 1'b1;
               MODE_QRY: answer_q.push_back(common_alive(req_node_a, req_node_b));
               default: ;
            endcase
         end
      end
   end

endmodule

### sim/testbench.sv
module testbench import lca_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [1:0]      req_mode = MODE_ADD;
   logic [ID_W-1:0] req_node_a = 1;
   logic [ID_W-1:0] req_node_b = 1;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [ID_W-1:0] rsp_ancestor;
   int              pending_answers;
   int              error_count;

   int  tree_size = 2;
   bit  steady = 1'b0;
   bit  hold_off = 1'b0;
   bit  hold_done = 1'b0;

   always #5 clock = ~clock;

   lca_alive_ancestor_engine_unit u_dut (.*);

   lca_checker u_checker (.*);

   task automatic put_beat(logic [1:0] m, logic [ID_W-1:0] a, logic [ID_W-1:0] b);
      if (!steady && $urandom_range(99) < 17) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_mode = m;
      req_node_a = a;
      req_node_b = b;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (m == MODE_ADD && tree_size < MAX_NODES) tree_size++;
      @(negedge clock);
   endtask

   function automatic logic [ID_W-1:0] some_node();
      return ID_W'($urandom_range(tree_size - 1, 1));
   endfunction

   // favor the newest node so chains grow deep
   function automatic logic [ID_W-1:0] some_parent();
      return ($urandom_range(1)) ? ID_W'(tree_size - 1) : some_node();
   endfunction

   task automatic random_beat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35)
         put_beat(MODE_ADD, some_parent(), ID_W'($urandom));
      else if (pick < 50)
         put_beat(MODE_DEL,
                  (tree_size > 2) ? ID_W'($urandom_range(tree_size - 1, 2)) : ID_W'(2),
                  ID_W'($urandom));
      else if (pick < 53)
         put_beat(MODE_DEL, ID_W'($urandom_range(MAX_NODES - 1, 2)), ID_W'($urandom));
      else if (pick < 97)
         put_beat(MODE_QRY, some_node(), some_node());
      else
         put_beat(MODE_NOP, ID_W'($urandom), ID_W'($urandom));
   endtask

   // response side: random stalls, one quiet stretch, one long hold-off
   initial begin
      @(negedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready = steady || ($urandom_range(99) >= 17);
         @(negedge clock);
      end
   end

   initial begin
      #100ms;
      $display("[lca_alive_ancestor_engine_unit] ERROR");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: root query, chain growth, same node, deep vs shallow
      put_beat(MODE_QRY, 1, 1);
      put_beat(MODE_NOP, 1023, 1023);
      for (int i = 0; i < 6; i++) put_beat(MODE_ADD, ID_W'(tree_size - 1), 0);
      put_beat(MODE_ADD, 1, 0);
      put_beat(MODE_ADD, 3, 0);
      put_beat(MODE_QRY, 7, 7);
      put_beat(MODE_QRY, 7, 2);
      put_beat(MODE_QRY, 8, 9);
      put_beat(MODE_QRY, 9, 7);
      put_beat(MODE_DEL, 3, 0);
      put_beat(MODE_DEL, 2, 0);
      put_beat(MODE_QRY, 7, 9);
      put_beat(MODE_QRY, 4, 5);
      put_beat(MODE_DEL, 12, 0);
      put_beat(MODE_ADD, 6, 0);
      put_beat(MODE_ADD, 10, 0);
      put_beat(MODE_ADD, 11, 0);
      put_beat(MODE_QRY, 12, 9);
      put_beat(MODE_DEL, 1023, 0);

      for (int i = 0; i < 150; i++) random_beat();
      hold_off = 1'b1;
      for (int i = 0; i < 30; i++) put_beat(MODE_QRY, some_node(), some_node());
      steady = 1'b1;
      for (int i = 0; i < 80; i++) random_beat();
      steady = 1'b0;
      for (int i = 0; i < 110; i++) random_beat();
      for (int i = 0; i < 50; i++) random_beat();

      // root gone: the chase ends on the root itself
      put_beat(MODE_DEL, 1, 0);
      for (int i = 0; i < 4; i++) put_beat(MODE_QRY, some_node(), some_node());
      req_valid = 1'b0;

      wait (pending_answers == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("[lca_alive_ancestor_engine_unit] OK");
      else
         $display("[lca_alive_ancestor_engine_unit] ERROR");
      $finish;
   end

endmodule
